/* design/sha_pkg.sv */
// SHA-256 shared package: round constants, initial hash values, a rotate-right
// function and the controller-to-datapath command/status types. No dependencies.
package sha_pkg;

	localparam logic [31:0] IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] KROUND [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// byte-lane source selected by the controller when writing the buffer
	localparam logic [1:0] SRC_MSG  = 2'd0;
	localparam logic [1:0] SRC_PAD  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;
	localparam logic [1:0] SRC_LEN  = 2'd3;

	typedef struct packed {
		logic       buf_wr;     // write one buffer byte
		logic [5:0] buf_addr;
		logic [1:0] buf_src;
		logic       cnt_inc;    // advance the byte count
		logic       cnt_clr;
		logic       load;       // load working vars from the chain
		logic       round;      // run one round
		logic [5:0] rnd;
		logic       fold;       // add working vars into the chain
		logic       chain_init; // return chain to IV
		logic       out_shift;  // rotate the chain for output
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] used;       // byte count modulo 64
	} sha_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* design/sha_datapath.sv */
// SHA-256 datapath: byte count, schedule window (which also collects the block
// bytes), working variables and chaining state. Depends on sha_pkg.
module sha_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::sha_cmd_t cmd,
	input  logic [7:0]        msg_byte,
	output sha_pkg::sha_stat_t stat,
	output logic [31:0]       head_word
);

	logic [60:0] cnt_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [63:0] bits;
	logic [7:0]  wbyte;
	logic [31:0] wt, s0, s1, t1, t2, a, e;

	assign bits = {cnt_q, 3'b000};
	assign stat.used = cnt_q[5:0];
	assign head_word = h_q[0];

	// choose the byte to write
	always_comb begin
		case (cmd.buf_src)
			sha_pkg::SRC_MSG:  wbyte = msg_byte;
			sha_pkg::SRC_PAD:  wbyte = sha_pkg::PAD_BYTE;
			sha_pkg::SRC_ZERO: wbyte = 8'h00;
			sha_pkg::SRC_LEN:  wbyte = bits[8*(7 - cmd.buf_addr[2:0]) +: 8];
			default:           wbyte = 8'h00;
		endcase
	end

	// advance or clear the byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 61'd1;
		end
	end

	// round logic; window slot 0 always holds the current W
	always_comb begin
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wt = s1 + w_q[9] + s0 + w_q[0];
		a = v_q[0];
		e = v_q[4];
		t1 = v_q[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::KROUND[cmd.rnd] + w_q[0];
		t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// pack block bytes big-endian into the window, or shift it each round
	always_ff @(posedge clk) begin
		if (cmd.buf_wr) begin
			w_q[cmd.buf_addr[5:2]][{~cmd.buf_addr[1:0], 3'b000} +: 8] <= wbyte;
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wt;
		end
	end

	// load and advance the working variables
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			for (int i = 1; i < 8; i++) begin
				v_q[i] <= v_q[i-1];
			end
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end
	end

	// fold, reset and rotate the chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::IV[i];
		end else if (cmd.chain_init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::IV[i];
		end else if (cmd.fold) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end else if (cmd.out_shift) begin
			for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
			h_q[7] <= h_q[0];
		end
	end

endmodule

/* design/sha_ctrl.sv */
// SHA-256 controller: input handshake, padding sequence, round counter and
// digest output sequencing. Depends on sha_pkg.
module sha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               byte_valid,
	input  logic               msg_last,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               digest_last,
	input  sha_pkg::sha_stat_t stat,
	output sha_pkg::sha_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FOLD  = 3'd3;
	localparam logic [2:0] ST_PAD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [5:0] rnd_q;
	logic [5:0] paddr_q;
	logic       fin_q;      // message is ending
	logic       lenblk_q;   // padding block carries the length
	logic [2:0] oc_q;
	logic       acc;

	assign in_stall = (state_q != ST_IDLE);
	assign acc = in_valid && (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign digest_last = (oc_q == 3'd7);

	// decode commands
	always_comb begin
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.buf_addr = stat.used;
		case (state_q)
			ST_IDLE: begin
				cmd.buf_wr = acc && byte_valid;
				cmd.buf_src = sha_pkg::SRC_MSG;
				cmd.cnt_inc = acc && byte_valid;
			end
			ST_LOAD:  cmd.load = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_FOLD:  cmd.fold = 1'b1;
			ST_PAD: begin
				cmd.buf_wr = 1'b1;
				cmd.buf_addr = paddr_q;
				if (paddr_q == stat.used && !lenblk_q) begin
					cmd.buf_src = sha_pkg::SRC_PAD;
				end else if (lenblk_q && paddr_q >= 6'd56) begin
					cmd.buf_src = sha_pkg::SRC_LEN;
				end else if (!lenblk_q && paddr_q == stat.used) begin
					cmd.buf_src = sha_pkg::SRC_PAD;
				end else begin
					cmd.buf_src = sha_pkg::SRC_ZERO;
				end
			end
			ST_OUT: begin
				cmd.out_shift = !out_stall;
				if (!out_stall && oc_q == 3'd7) begin
					cmd.chain_init = 1'b1;
					cmd.cnt_clr = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			paddr_q <= '0;
			fin_q <= 1'b0;
			lenblk_q <= 1'b0;
			oc_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						fin_q <= msg_last;
						lenblk_q <= 1'b0;
						if (byte_valid && stat.used == 6'd63) begin
							state_q <= ST_LOAD;
						end else if (msg_last) begin
							// first pad write lands at the pad byte position
							paddr_q <= byte_valid ? stat.used + 6'd1 : stat.used;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// pad byte goes into the first block only
					if (paddr_q == 6'd63) begin
						state_q <= ST_LOAD;
					end
					paddr_q <= paddr_q + 6'd1;
					if (paddr_q == stat.used && !lenblk_q && stat.used < 6'd56) begin
						lenblk_q <= 1'b1;
					end
				end
				ST_LOAD: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (lenblk_q) begin
						oc_q <= '0;
						state_q <= ST_OUT;
					end else begin
						// second padding block: zeros then length; a full final
						// block instead opens a fresh block with the pad byte
						lenblk_q <= (stat.used != 6'd0);
						paddr_q <= '0;
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						oc_q <= oc_q + 3'd1;
						if (oc_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* design/sha256_stream_hasher_top.sv */
// SHA-256 stream hasher, top level. A byte is taken while in_stall is low; a 64th
// byte starts a compression (load, 64 rounds, fold) on one round unit.
// An ending item pads byte by byte, one padding block at a time, compresses,
// then shows eight digest words, one per cycle when not stalled.
// Reset (arst_n low) returns chain to the initial values and clears count.
module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_valid,
	input  logic        msg_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        digest_last
);

	sha_pkg::sha_cmd_t  cmd;
	sha_pkg::sha_stat_t stat;

	sha_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .byte_valid, .msg_last,
		.out_stall, .out_valid, .digest_last, .stat, .cmd
	);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .msg_byte, .stat, .head_word(digest_word)
	);

endmodule
